// ===== hdl/gsps_pkg.sv =====
// Shared types, constants and helpers for the glyph renderer.
package gsps_pkg;

  localparam int unsigned DISPLAY_WIDTH  = 320;
  localparam int unsigned DISPLAY_HEIGHT = 240;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic CMD_BEGIN = 1'b0;
  localparam logic CMD_GLYPH = 1'b1;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_BAD_CODE    = 2'd1;
  localparam logic [1:0] ST_OFF_DISPLAY = 2'd2;

  localparam logic [7:0] LCD_COL_SET   = 8'h2A;
  localparam logic [7:0] LCD_PAGE_SET  = 8'h2B;
  localparam logic [7:0] LCD_MEM_WRITE = 8'h2C;

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_CODE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_CODE    = 3'd5;

  localparam logic [1:0] JOB_ERR = 2'd0;
  localparam logic [1:0] JOB_WIN = 2'd1;
  localparam logic [1:0] JOB_PIX = 2'd2;

  // window setup sequence: commands and address bytes
  localparam logic [3:0] WIN_LAST_STEP = 4'd10;

  typedef struct packed {
    logic        command;
    logic [15:0] start_col;
    logic [15:0] start_row;
    logic [7:0]  char_code;
    logic [7:0]  glyph_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic [1:0] status;
    logic       glyph_end;
    logic       last;
  } out_word_t;

  // live configuration, geometry already clamped to 1..32
  typedef struct packed {
    logic [15:0] fg_color;
    logic [15:0] bg_color;
    logic [5:0]  width;
    logic [5:0]  height;
    logic [7:0]  first_code;
    logic [7:0]  last_code;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [15:0] col;
    logic [15:0] col_end;
    logic [15:0] row;
    logic [15:0] row_end;
    logic [7:0]  gbyte;
    logic [3:0]  npix;
    logic        closing;
  } job_t;

  function automatic logic [5:0] clamp_dim(input logic [5:0] v);
    logic [5:0] r;
    r = v;
    if (v == 6'd0) r = 6'd1;
    else if (v > 6'd32) r = 6'd32;
    return r;
  endfunction

endpackage

// ===== hdl/gsps_queue.sv =====
// Short job queue between the front and back parts.
module gsps_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  gsps_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output gsps_pkg::job_t pop_job,
  output logic          empty
);
  import gsps_pkg::*;

  job_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              do_push, do_pop;

  assign full    = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (!do_push && do_pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_job;
  end

endmodule

// ===== hdl/gsps_front.sv =====
// Front part: accepts words, tracks the open character and queues jobs.
module gsps_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  gsps_pkg::in_word_t in_word,
  input  gsps_pkg::cfg_t    cfg,
  input  logic              q_full,
  output logic              job_push,
  output gsps_pkg::job_t    job
);
  import gsps_pkg::*;

  logic       glyph_open_r, glyph_open_nxt;
  logic [4:0] pixel_in_row_r, pixel_in_row_nxt;
  logic [4:0] row_in_glyph_r, row_in_glyph_nxt;

  logic        accept;
  logic        bad_code, off_display;
  logic [16:0] col_room, row_room;
  logic [16:0] col_end_w, row_end_w;
  logic [5:0]  left_in_row;
  logic [3:0]  npix;
  logic [5:0]  pos;
  logic [5:0]  row_inc;
  logic        row_done, closing;

  assign accept  = in_push && !q_full;
  assign in_full = q_full;

  always_comb begin
    bad_code = (in_word.char_code < cfg.first_code) || (in_word.char_code > cfg.last_code);
    col_room = 17'(DISPLAY_WIDTH) - {1'b0, in_word.start_col};
    row_room = 17'(DISPLAY_HEIGHT) - {1'b0, in_word.start_row};
    off_display = ({1'b0, in_word.start_col} > 17'(DISPLAY_WIDTH - 1))
               || ({1'b0, in_word.start_row} > 17'(DISPLAY_HEIGHT - 1))
               || (17'(cfg.width) > col_room)
               || (17'(cfg.height) > row_room);
    col_end_w = {1'b0, in_word.start_col} + 17'(cfg.width) - 17'd1;
    row_end_w = {1'b0, in_word.start_row} + 17'(cfg.height) - 17'd1;

    // pixels this byte covers: what is left of the row, at most eight
    left_in_row = ({1'b0, pixel_in_row_r} < cfg.width)
                ? cfg.width - {1'b0, pixel_in_row_r} : 6'd0;
    npix     = (left_in_row > 6'd8) ? 4'd8 : left_in_row[3:0];
    pos      = {1'b0, pixel_in_row_r} + 6'(npix);
    row_inc  = {1'b0, row_in_glyph_r} + 6'd1;
    row_done = (pos >= cfg.width);
    closing  = row_done && (row_inc >= cfg.height);
  end

  always_comb begin
    glyph_open_nxt   = glyph_open_r;
    pixel_in_row_nxt = pixel_in_row_r;
    row_in_glyph_nxt = row_in_glyph_r;
    job_push         = 1'b0;
    job.kind         = JOB_ERR;
    job.status       = ST_OK;
    job.col          = in_word.start_col;
    job.col_end      = col_end_w[15:0];
    job.row          = in_word.start_row;
    job.row_end      = row_end_w[15:0];
    job.gbyte        = in_word.glyph_byte;
    job.npix         = npix;
    job.closing      = closing;
    if (accept) begin
      if (in_word.command == CMD_BEGIN) begin
        job_push         = 1'b1;
        pixel_in_row_nxt = '0;
        row_in_glyph_nxt = '0;
        glyph_open_nxt   = 1'b0;
        if (bad_code) begin
          job.status = ST_BAD_CODE;
        end else if (off_display) begin
          job.status = ST_OFF_DISPLAY;
        end else begin
          job.kind       = JOB_WIN;
          glyph_open_nxt = 1'b1;
        end
      end else if (glyph_open_r) begin
        job.kind = JOB_PIX;
        job_push = (npix != 4'd0);
        if (row_done) begin
          pixel_in_row_nxt = '0;
          row_in_glyph_nxt = closing ? 5'd0 : row_inc[4:0];
          if (closing) glyph_open_nxt = 1'b0;
        end else begin
          pixel_in_row_nxt = pos[4:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glyph_open_r   <= 1'b0;
      pixel_in_row_r <= '0;
      row_in_glyph_r <= '0;
    end else begin
      glyph_open_r   <= glyph_open_nxt;
      pixel_in_row_r <= pixel_in_row_nxt;
      row_in_glyph_r <= row_in_glyph_nxt;
    end
  end

endmodule

// ===== hdl/gsps_back.sv =====
// Back part: expands queued jobs into link bytes, one word per cycle while the result side takes them.
module gsps_back (
  input  logic               clk,
  input  logic               rst_n,
  input  gsps_pkg::cfg_t     cfg,
  input  logic               q_empty,
  input  gsps_pkg::job_t     job,
  output logic               q_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output gsps_pkg::out_word_t out_word
);
  import gsps_pkg::*;

  logic [3:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_word_t  out_word_r;
  out_word_t  word;
  logic       emit;
  logic [2:0] pix_idx;
  logic       pix_bit;
  logic [15:0] color;
  logic       pix_fin;

  assign emit      = !q_empty && (!out_valid_r || out_pop);
  assign out_empty = !out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    pix_idx = step_r[3:1];
    pix_bit = job.gbyte[3'd7 - pix_idx];
    color   = pix_bit ? cfg.fg_color : cfg.bg_color;
    pix_fin = step_r[0] && ({1'b0, pix_idx} == job.npix - 4'd1);

    word.out_byte  = 8'd0;
    word.is_data   = 1'b0;
    word.status    = ST_OK;
    word.glyph_end = 1'b0;
    word.last      = 1'b0;
    unique case (job.kind)
      JOB_WIN: begin
        word.is_data = 1'b1;
        word.last    = (step_r == WIN_LAST_STEP);
        unique case (step_r)
          4'd0: begin
            word.out_byte = LCD_COL_SET;
            word.is_data  = 1'b0;
          end
          4'd1: word.out_byte = job.col[15:8];
          4'd2: word.out_byte = job.col[7:0];
          4'd3: word.out_byte = job.col_end[15:8];
          4'd4: word.out_byte = job.col_end[7:0];
          4'd5: begin
            word.out_byte = LCD_PAGE_SET;
            word.is_data  = 1'b0;
          end
          4'd6: word.out_byte = job.row[15:8];
          4'd7: word.out_byte = job.row[7:0];
          4'd8: word.out_byte = job.row_end[15:8];
          4'd9: word.out_byte = job.row_end[7:0];
          default: begin
            word.out_byte = LCD_MEM_WRITE;
            word.is_data  = 1'b0;
          end
        endcase
      end
      JOB_PIX: begin
        word.out_byte  = step_r[0] ? color[7:0] : color[15:8];
        word.is_data   = 1'b1;
        word.glyph_end = pix_fin && job.closing;
        word.last      = pix_fin;
      end
      default: begin
        word.status = job.status;
        word.last   = 1'b1;
      end
    endcase

    q_pop         = emit && word.last;
    step_nxt      = step_r;
    if (emit) step_nxt = word.last ? 4'd0 : step_r + 4'd1;
    out_valid_nxt = out_valid_r;
    if (emit) out_valid_nxt = 1'b1;
    else if (out_pop) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) out_word_r <= word;
  end

endmodule

// ===== hdl/glyph_to_spi_pixel_stream_top.sv =====
// Top level: configuration registers, front part, job queue and back part.
// The first result word of an input word passes the job queue and the output
// register. The back part gives one result word per cycle while the result
// side takes them; a begin gives 11 words (1 on an error), a glyph byte 2 per
// pixel, up to 16.
// Input words are taken every cycle while the 4-entry job queue has room.
// Reset (rst_n low, synchronous): registers to defaults, no open character,
// queue and output empty.
module glyph_to_spi_pixel_stream_top (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_push,
  output logic                                   in_full,
  input  gsps_pkg::in_word_t                      in_word,
  output logic                                   out_empty,
  input  logic                                   out_pop,
  output gsps_pkg::out_word_t                     out_word,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [gsps_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [15:0]                            cfg_data
);
  import gsps_pkg::*;

  logic [15:0] fg_color_r, bg_color_r;
  logic [5:0]  glyph_width_r, glyph_height_r;
  logic [7:0]  first_code_r, last_code_r;
  cfg_t        cfg;
  logic        q_full, q_empty, q_push, q_pop;
  job_t        push_job, head_job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_color_r     <= 16'hFFFF;
      bg_color_r     <= 16'h0000;
      glyph_width_r  <= 6'd8;
      glyph_height_r <= 6'd16;
      first_code_r   <= 8'd32;
      last_code_r    <= 8'd126;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FG_COLOR:     fg_color_r     <= cfg_data;
        REG_BG_COLOR:     bg_color_r     <= cfg_data;
        REG_GLYPH_WIDTH:  glyph_width_r  <= cfg_data[5:0];
        REG_GLYPH_HEIGHT: glyph_height_r <= cfg_data[5:0];
        REG_FIRST_CODE:   first_code_r   <= cfg_data[7:0];
        REG_LAST_CODE:    last_code_r    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.fg_color   = fg_color_r;
    cfg.bg_color   = bg_color_r;
    cfg.width      = clamp_dim(glyph_width_r);
    cfg.height     = clamp_dim(glyph_height_r);
    cfg.first_code = first_code_r;
    cfg.last_code  = last_code_r;
  end

  gsps_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_word  (in_word),
    .cfg      (cfg),
    .q_full   (q_full),
    .job_push (q_push),
    .job      (push_job)
  );

  gsps_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (head_job),
    .empty    (q_empty)
  );

  gsps_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .job       (head_job),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word)
  );

endmodule

// ===== hdl/gsps_checker.sv =====
// Port-level checks on the result side of the glyph renderer, with bind.
module gsps_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_empty,
  input logic                out_pop,
  input gsps_pkg::out_word_t out_word
);
  import gsps_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result side not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_word)))
    else $error("waiting result word changed or dropped");

  a_error_word: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_word.status != ST_OK) |->
      (out_word.last && !out_word.is_data && !out_word.glyph_end))
    else $error("error word not a lone command-side word");

  a_glyph_end: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_word.glyph_end) |->
      (out_word.last && out_word.is_data && out_word.status == ST_OK))
    else $error("glyph end not on the last pixel byte");

endmodule

bind glyph_to_spi_pixel_stream_top gsps_checker u_gsps_checker (.*);
